// File: design/urb_pkg.sv
// Shared types, codes and sizes of the UART ring buffer engine.
package urb_pkg;

  localparam int RX_DEPTH = 64;
  localparam int TX_DEPTH = 64;

  localparam int RX_PTR_W = $clog2(RX_DEPTH);
  localparam int TX_PTR_W = $clog2(TX_DEPTH);
  localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
  localparam int MARK_W = 7;
  localparam int RX_CMP_W = (RX_CNT_W > MARK_W) ? RX_CNT_W : MARK_W;

  localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
  localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);

  localparam int CMD_W = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LINE_BYTE  = 3'd0,
    CMD_HOST_READ  = 3'd1,
    CMD_HOST_WRITE = 3'd2,
    CMD_TX_READY   = 3'd3,
    CMD_FLUSH      = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESET_CMD   = 3'd0,
    CFG_STATUS_CMD  = 3'd1,
    CFG_START_CMD   = 3'd2,
    CFG_ABORT_CMD   = 3'd3,
    CFG_LOW_MARK    = 3'd4,
    CFG_RELEASE_MRK = 3'd5
  } cfg_idx_t;

  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_RESET       = 3'd1;
  localparam logic [2:0] EV_STATUS      = 3'd2;
  localparam logic [2:0] EV_START       = 3'd3;
  localparam logic [2:0] EV_ABORT       = 3'd4;
  localparam logic [2:0] EV_RX_OVERFLOW = 3'd5;
  localparam logic [2:0] EV_TX_OVERFLOW = 3'd6;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_AVAIL = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [7:0] FLOW_FULL_CHAR  = 8'h66;
  localparam logic [7:0] FLOW_AVAIL_CHAR = 8'h61;

  localparam logic [7:0] RESET_CMD_DEF  = 8'd24;
  localparam logic [7:0] STATUS_CMD_DEF = 8'd63;
  localparam logic [7:0] START_CMD_DEF  = 8'd126;
  localparam logic [7:0] ABORT_CMD_DEF  = 8'd33;
  localparam logic [MARK_W-1:0] LOW_MARK_DEF     = 7'd10;
  localparam logic [MARK_W-1:0] RELEASE_MARK_DEF = 7'd20;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

// File: design/urb_ctrl.sv
// Controller state machine that sequences one command through the datapath.
module urb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output urb_pkg::ctrl_t ctrl
);
  import urb_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = start ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: state_nxt = start ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    ctrl.exec = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        busy      = 1'b1;
        ctrl.exec = 1'b1;
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
    ctrl.load = accept;
  end

endmodule

// File: design/urb_datapath.sv
// Ring pointers, byte stores, flow control flags and configuration registers.
module urb_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  urb_pkg::ctrl_t                 ctrl,
  input  logic [urb_pkg::CMD_W-1:0]      in_cmd,
  input  logic [7:0]                     in_data,
  input  logic                           cfg_we,
  input  logic [urb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [urb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [6:0]                     out_rx_byte,
  output logic                           out_rx_byte_valid,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_tx_byte_valid,
  output logic [2:0]                     out_event_res,
  output logic [1:0]                     out_rx_status,
  output logic [1:0]                     out_tx_status,
  output logic                           out_rx_full_flag
);
  import urb_pkg::*;

  function automatic logic [RX_PTR_W-1:0] rx_next(input logic [RX_PTR_W-1:0] p);
    return (p == RX_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TX_PTR_W-1:0] tx_next(input logic [TX_PTR_W-1:0] p);
    return (p == TX_LAST) ? '0 : p + 1'b1;
  endfunction

  // Free space of the receive ring; an empty ring counts as fully free.
  function automatic logic [RX_CMP_W-1:0] rx_free(input logic [RX_PTR_W-1:0] w,
                                                   input logic [RX_PTR_W-1:0] r);
    logic [RX_CNT_W-1:0] used;
    if (w >= r) begin
      used = RX_CNT_W'(w) - RX_CNT_W'(r);
    end else begin
      used = RX_CNT_W'(w) + RX_CNT_W'(RX_DEPTH) - RX_CNT_W'(r);
    end
    return RX_CMP_W'(RX_CNT_W'(RX_DEPTH) - used);
  endfunction

  logic [7:0] reset_cmd_r, status_cmd_r, start_cmd_r, abort_cmd_r;
  logic [MARK_W-1:0] low_mark_r, release_mark_r;

  logic [CMD_W-1:0] cmd_r;
  logic [7:0]       data_r;

  logic [RX_PTR_W-1:0] rx_w_r, rx_w_nxt, rx_r_r, rx_r_nxt;
  logic [TX_PTR_W-1:0] tx_w_r, tx_w_nxt, tx_r_r, tx_r_nxt;
  logic almost_full_r, almost_full_nxt, reported_r, reported_nxt;

  logic rx_valid_r, rx_valid_nxt;
  logic tx_valid_r, tx_valid_nxt;
  logic tx_from_mem_r, tx_from_mem_nxt;
  logic [7:0] tx_flow_r, tx_flow_nxt;
  logic [2:0] event_r, event_nxt;

  logic [6:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [6:0] rx_rd_q;
  logic [7:0] tx_rd_q;

  logic                rx_we, rx_re, tx_we, tx_re;
  logic [RX_PTR_W-1:0] rx_h, rx_t;
  logic [TX_PTR_W-1:0] tx_h, tx_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_cmd_r    <= RESET_CMD_DEF;
      status_cmd_r   <= STATUS_CMD_DEF;
      start_cmd_r    <= START_CMD_DEF;
      abort_cmd_r    <= ABORT_CMD_DEF;
      low_mark_r     <= LOW_MARK_DEF;
      release_mark_r <= RELEASE_MARK_DEF;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_RESET_CMD:   reset_cmd_r    <= cfg_wdata[7:0];
        CFG_STATUS_CMD:  status_cmd_r   <= cfg_wdata[7:0];
        CFG_START_CMD:   start_cmd_r    <= cfg_wdata[7:0];
        CFG_ABORT_CMD:   abort_cmd_r    <= cfg_wdata[7:0];
        CFG_LOW_MARK:    low_mark_r     <= cfg_wdata[MARK_W-1:0];
        CFG_RELEASE_MRK: release_mark_r <= cfg_wdata[MARK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= in_cmd;
      data_r <= in_data;
    end
  end

  assign rx_h = rx_next(rx_w_r);
  assign rx_t = rx_next(rx_r_r);
  assign tx_h = tx_next(tx_w_r);
  assign tx_t = tx_next(tx_r_r);

  always_comb begin
    rx_w_nxt        = rx_w_r;
    rx_r_nxt        = rx_r_r;
    tx_w_nxt        = tx_w_r;
    tx_r_nxt        = tx_r_r;
    almost_full_nxt = almost_full_r;
    reported_nxt    = reported_r;
    rx_valid_nxt    = 1'b0;
    tx_valid_nxt    = 1'b0;
    tx_from_mem_nxt = 1'b0;
    tx_flow_nxt     = '0;
    event_nxt       = EV_NONE;
    rx_we           = 1'b0;
    rx_re           = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    unique case (cmd_t'(cmd_r))
      CMD_LINE_BYTE: begin
        priority if (data_r == reset_cmd_r) begin
          event_nxt = EV_RESET;
        end else if (data_r == status_cmd_r) begin
          event_nxt = EV_STATUS;
        end else if (data_r == start_cmd_r) begin
          event_nxt = EV_START;
        end else if (data_r == abort_cmd_r) begin
          event_nxt = EV_ABORT;
        end else if (!data_r[7]) begin
          if (rx_h != rx_r_r) begin
            rx_we    = 1'b1;
            rx_w_nxt = rx_h;
          end else begin
            event_nxt = EV_RX_OVERFLOW;
          end
          // The low-mark test runs even when the byte was dropped.
          if (rx_free(rx_w_nxt, rx_r_r) < RX_CMP_W'(low_mark_r)) begin
            almost_full_nxt = 1'b1;
          end
        end else begin
        end
      end
      CMD_HOST_READ: begin
        if (rx_w_r != rx_r_r) begin
          rx_re        = 1'b1;
          rx_valid_nxt = 1'b1;
          rx_r_nxt     = rx_t;
          if (rx_free(rx_w_r, rx_t) > RX_CMP_W'(release_mark_r)) begin
            almost_full_nxt = 1'b0;
          end
        end
      end
      CMD_HOST_WRITE: begin
        if (tx_h != tx_r_r) begin
          tx_we    = 1'b1;
          tx_w_nxt = tx_h;
        end else begin
          event_nxt = EV_TX_OVERFLOW;
        end
      end
      CMD_TX_READY: begin
        if (almost_full_r != reported_r) begin
          tx_valid_nxt = 1'b1;
          tx_flow_nxt  = almost_full_r ? FLOW_FULL_CHAR : FLOW_AVAIL_CHAR;
          reported_nxt = almost_full_r;
        end else if (tx_w_r != tx_r_r) begin
          tx_re           = 1'b1;
          tx_valid_nxt    = 1'b1;
          tx_from_mem_nxt = 1'b1;
          tx_r_nxt        = tx_t;
        end
      end
      CMD_FLUSH: begin
        rx_w_nxt = '0;
        rx_r_nxt = '0;
        tx_w_nxt = '0;
        tx_r_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_w_r        <= '0;
      rx_r_r        <= '0;
      tx_w_r        <= '0;
      tx_r_r        <= '0;
      almost_full_r <= 1'b0;
      reported_r    <= 1'b0;
    end else if (ctrl.exec) begin
      rx_w_r        <= rx_w_nxt;
      rx_r_r        <= rx_r_nxt;
      tx_w_r        <= tx_w_nxt;
      tx_r_r        <= tx_r_nxt;
      almost_full_r <= almost_full_nxt;
      reported_r    <= reported_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      rx_valid_r    <= rx_valid_nxt;
      tx_valid_r    <= tx_valid_nxt;
      tx_from_mem_r <= tx_from_mem_nxt;
      tx_flow_r     <= tx_flow_nxt;
      event_r       <= event_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && rx_we) begin
      rx_mem[rx_h] <= data_r[6:0];
    end
    if (ctrl.exec && rx_re) begin
      rx_rd_q <= rx_mem[rx_t];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && tx_we) begin
      tx_mem[tx_h] <= data_r;
    end
    if (ctrl.exec && tx_re) begin
      tx_rd_q <= tx_mem[tx_t];
    end
  end

  assign out_rx_byte       = rx_valid_r ? rx_rd_q : '0;
  assign out_rx_byte_valid = rx_valid_r;
  assign out_tx_byte       = tx_from_mem_r ? tx_rd_q : tx_flow_r;
  assign out_tx_byte_valid = tx_valid_r;
  assign out_event_res     = event_r;
  assign out_rx_full_flag  = almost_full_r;

  // Ring status is taken from the pointers after the command has been applied.
  always_comb begin
    priority if (rx_w_r == rx_r_r) begin
      out_rx_status = ST_EMPTY;
    end else if (rx_h == rx_r_r) begin
      out_rx_status = ST_FULL;
    end else begin
      out_rx_status = ST_AVAIL;
    end
  end

  always_comb begin
    priority if (almost_full_r != reported_r) begin
      out_tx_status = ST_AVAIL;
    end else if (tx_w_r == tx_r_r) begin
      out_tx_status = ST_EMPTY;
    end else if (tx_h == tx_r_r) begin
      out_tx_status = ST_FULL;
    end else begin
      out_tx_status = ST_AVAIL;
    end
  end

endmodule

// File: design/uart_ring_buffers_with_flow_control_unit.sv
// Top level of the UART ring buffer engine with software flow control.
// A command taken at an edge is executed, and its result strobe follows in the
// done state. No new command is taken while one executes; the store read port
// is registered, so each command passes an execute state and a result state.
// A new command is taken in the cycle its predecessor's result is shown.
// Reset (synchronous, active low) empties both rings, clears the flow flags and
// restores the default command bytes and marks; the results cannot be stalled.
module uart_ring_buffers_with_flow_control_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [urb_pkg::CMD_W-1:0]      in_cmd,
  input  logic [7:0]                     in_data,
  output logic                           out_valid,
  output logic [6:0]                     out_rx_byte,
  output logic                           out_rx_byte_valid,
  output logic [7:0]                     out_tx_byte,
  output logic                           out_tx_byte_valid,
  output logic [2:0]                     out_event_res,
  output logic [1:0]                     out_rx_status,
  output logic [1:0]                     out_tx_status,
  output logic                           out_rx_full_flag,
  input  logic                           cfg_we,
  input  logic [urb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [urb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import urb_pkg::*;

  ctrl_t ctrl;

  urb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  urb_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .in_cmd            (in_cmd),
    .in_data           (in_data),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .out_rx_byte       (out_rx_byte),
    .out_rx_byte_valid (out_rx_byte_valid),
    .out_tx_byte       (out_tx_byte),
    .out_tx_byte_valid (out_tx_byte_valid),
    .out_event_res     (out_event_res),
    .out_rx_status     (out_rx_status),
    .out_tx_status     (out_tx_status),
    .out_rx_full_flag  (out_rx_full_flag)
  );

  // Every accepted transfer is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command was not executed");

  // Execution is always followed by exactly one result strobe.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execution cycle not followed by a result");

  // A result strobe only follows an execution cycle.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a command");

  // A host read never reports an event and empty reads return zero.
  a_rx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rx_byte_valid) |-> (out_rx_byte == 7'd0))
    else $error("receive byte not zero on an empty read");

  a_rx_valid_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rx_byte_valid) |-> (out_event_res == EV_NONE && !out_tx_byte_valid))
    else $error("host read reported an event or a transmit byte");

endmodule
